>>> src/text_terminal_screen_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Text terminal screen writer: assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCREEN_WRITER_CORE_DEFINES_SVH
`define TEXT_TERMINAL_SCREEN_WRITER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TTSW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define TTSW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ttsw_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal screen writer package
// Field widths, operation codes, character constants and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsw_pkg;

	// Port field widths
	localparam int OPCODE_W = 3;
	localparam int CHAR_W   = 8;
	localparam int COL_X_W  = 7;
	localparam int ROW_Y_W  = 5;
	localparam int ATTR_W   = 8;
	localparam int POS_W    = 11;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	// Operation codes
	localparam logic [OPCODE_W-1:0] OP_WRITE_CHAR  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_BACKSPACE   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_PUT_ATTR    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_PUT_DEFAULT = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_READ_CELL   = 3'd5;

	// Character and attribute constants
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_FILL,
		ST_DONE
	} ttsw_state_t;

endpackage

`default_nettype wire

>>> src/text_terminal_screen_writer_core.sv
// An item goes from IDLE through EXEC to DONE; a read cell adds the READ state, a
// scroll adds a FILL sweep of SCREEN_COLUMNS cells (one blanked cell per cycle
// through the single write port), a clear one of SCREEN_COLUMNS*SCREEN_ROWS cells.
// One item at a time: the next input beat waits until DONE has loaded the result.
// Reset: cursor homes and a clearing pass over SCREEN_COLUMNS*SCREEN_ROWS cells
// blanks the cell memory; no input beat is taken until it ends.
// ----------------------------------------------------------------------------
// Text terminal screen writer core
// Cell store in one synchronous memory, addressed as a ring of rows so that a
// scroll moves the top row pointer and blanks one row.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_terminal_screen_writer_core_defines.svh"

module text_terminal_screen_writer_core #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_wr_en,
	input  wire logic [ttsw_pkg::ATTR_W-1:0]  cfg_wr_data,
	// input channel
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [ttsw_pkg::OPCODE_W-1:0] opcode,
	input  wire logic [ttsw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [ttsw_pkg::COL_X_W-1:0] col_x,
	input  wire logic [ttsw_pkg::ROW_Y_W-1:0] row_y,
	input  wire logic [ttsw_pkg::ATTR_W-1:0]  attribute,
	// output channel
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      logic [ttsw_pkg::ROW_Y_W-1:0] cursor_line,
	output      logic [ttsw_pkg::COL_X_W-1:0] cursor_column,
	output      logic [ttsw_pkg::POS_W-1:0]   cursor_position,
	output      logic [ttsw_pkg::CHAR_W-1:0]  cell_char,
	output      logic [ttsw_pkg::ATTR_W-1:0]  cell_attr
);

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);
	localparam int ROW_W      = $clog2(SCREEN_ROWS);
	localparam int COL_W      = $clog2(SCREEN_COLUMNS);

	// State and configuration
	ttsw_pkg::ttsw_state_t state_q, state_d;
	logic [ttsw_pkg::ATTR_W-1:0] default_attr_q;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] top_q, top_d;

	// Captured item
	logic [ttsw_pkg::OPCODE_W-1:0] op_q;
	logic [ttsw_pkg::CHAR_W-1:0]   char_q;
	logic [ttsw_pkg::COL_X_W-1:0]  x_q;
	logic [ttsw_pkg::ROW_Y_W-1:0]  y_q;
	logic [ttsw_pkg::ATTR_W-1:0]   attr_q;

	// Fill sweep
	logic [ADDR_W-1:0]           fill_addr_q, fill_addr_d;
	logic [CNT_W-1:0]            fill_cnt_q, fill_cnt_d;
	logic [ttsw_pkg::CELL_W-1:0] fill_cell_q, fill_cell_d;

	// Read result and output register
	logic [ttsw_pkg::CELL_W-1:0] cell_q, cell_d;
	logic                        load_out;
	logic                        out_valid_q;
	logic [ttsw_pkg::ROW_Y_W-1:0] out_row_q;
	logic [ttsw_pkg::COL_X_W-1:0] out_col_q;
	logic [ttsw_pkg::POS_W-1:0]   out_pos_q;
	logic [ttsw_pkg::CELL_W-1:0]  out_cell_q;

	// Memory ports
	logic [ttsw_pkg::CELL_W-1:0] mem [CELL_COUNT];
	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [ttsw_pkg::CELL_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [ttsw_pkg::CELL_W-1:0] mem_rdata;

	// Address helpers
	logic [ROW_W-1:0]            bs_row;
	logic [COL_W-1:0]            bs_col;
	logic [ADDR_W-1:0]           cur_addr;
	logic [ADDR_W-1:0]           bs_addr;
	logic [ADDR_W-1:0]           xy_addr;
	logic [ADDR_W-1:0]           top_addr;
	logic [ROW_W-1:0]            top_inc;
	logic                        xy_on;
	logic                        col_last;
	logic                        row_last;
	logic [ADDR_W-1:0]           pos_full;
	logic [ttsw_pkg::CELL_W-1:0] blank_cell;

	// Assertion helpers
	logic                        cursor_in_range;
	logic                        in_work_state;

	// Map a screen row onto its memory row
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
		input logic [ROW_W-1:0] top);
		logic [ROW_W:0] sum;
		sum = {1'b0, r} + {1'b0, top};
		if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
			sum = sum - (ROW_W+1)'(SCREEN_ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	// Linear cell address of a memory row and column
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(c);
	endfunction

	assign blank_cell = {default_attr_q, ttsw_pkg::BLANK_CHAR};
	assign col_last   = (col_q == COL_W'(SCREEN_COLUMNS - 1));
	assign row_last   = (row_q == ROW_W'(SCREEN_ROWS - 1));
	assign top_inc    = (top_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + ROW_W'(1);
	assign xy_on      = (int'(x_q) < SCREEN_COLUMNS) && (int'(y_q) < SCREEN_ROWS);

	// Step back one cell, across a line; hold at home
	always_comb begin
		bs_row = row_q;
		bs_col = col_q;
		if (col_q != '0) begin
			bs_col = col_q - COL_W'(1);
		end else if (row_q != '0) begin
			bs_row = row_q - ROW_W'(1);
			bs_col = COL_W'(SCREEN_COLUMNS - 1);
		end
	end

	assign cur_addr = cell_addr(phys_row(row_q, top_q), col_q);
	assign bs_addr  = cell_addr(phys_row(bs_row, top_q), bs_col);
	assign xy_addr  = cell_addr(phys_row(ROW_W'(y_q), top_q), COL_W'(x_q));
	assign top_addr = cell_addr(top_q, '0);
	assign pos_full = ADDR_W'(row_q) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_q);

	// Next state, memory access and cursor update
	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		top_d       = top_q;
		fill_addr_d = fill_addr_q;
		fill_cnt_d  = fill_cnt_q;
		fill_cell_d = fill_cell_q;
		cell_d      = cell_q;
		load_out    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = fill_addr_q;
		mem_wdata   = fill_cell_q;
		mem_re      = 1'b0;
		case (state_q)
			ttsw_pkg::ST_INIT, ttsw_pkg::ST_FILL: begin
				mem_we      = 1'b1;
				fill_addr_d = fill_addr_q + ADDR_W'(1);
				fill_cnt_d  = fill_cnt_q - CNT_W'(1);
				if (fill_cnt_q == CNT_W'(1)) begin
					state_d = (state_q == ttsw_pkg::ST_INIT) ? ttsw_pkg::ST_IDLE
						: ttsw_pkg::ST_DONE;
				end
			end
			ttsw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ttsw_pkg::ST_EXEC;
				end
			end
			ttsw_pkg::ST_EXEC: begin
				cell_d      = '0;
				state_d     = ttsw_pkg::ST_DONE;
				fill_cell_d = blank_cell;
				case (op_q)
					ttsw_pkg::OP_WRITE_CHAR: begin
						if (char_q != ttsw_pkg::NEWLINE_CHAR) begin
							mem_we    = 1'b1;
							mem_waddr = cur_addr;
							mem_wdata = {default_attr_q, char_q};
						end
						if (char_q == ttsw_pkg::NEWLINE_CHAR || col_last) begin
							col_d = '0;
							if (row_last) begin
								// scroll: old top row becomes the blank bottom row
								top_d       = top_inc;
								fill_addr_d = top_addr;
								fill_cnt_d  = CNT_W'(SCREEN_COLUMNS);
								state_d     = ttsw_pkg::ST_FILL;
							end else begin
								row_d = row_q + ROW_W'(1);
							end
						end else begin
							col_d = col_q + COL_W'(1);
						end
					end
					ttsw_pkg::OP_BACKSPACE: begin
						mem_we    = 1'b1;
						mem_waddr = bs_addr;
						mem_wdata = blank_cell;
						row_d     = bs_row;
						col_d     = bs_col;
					end
					ttsw_pkg::OP_CLEAR: begin
						row_d       = '0;
						col_d       = '0;
						top_d       = '0;
						fill_addr_d = '0;
						fill_cnt_d  = CNT_W'(CELL_COUNT);
						state_d     = ttsw_pkg::ST_FILL;
					end
					ttsw_pkg::OP_PUT_ATTR: begin
						mem_we    = xy_on;
						mem_waddr = xy_addr;
						mem_wdata = {attr_q, char_q};
					end
					ttsw_pkg::OP_PUT_DEFAULT: begin
						mem_we    = xy_on;
						mem_waddr = xy_addr;
						mem_wdata = {default_attr_q, char_q};
					end
					ttsw_pkg::OP_READ_CELL: begin
						if (xy_on) begin
							mem_re  = 1'b1;
							state_d = ttsw_pkg::ST_READ;
						end
					end
					default: begin
					end
				endcase
			end
			ttsw_pkg::ST_READ: begin
				cell_d  = mem_rdata;
				state_d = ttsw_pkg::ST_DONE;
			end
			ttsw_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ttsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttsw_pkg::ST_IDLE;
			end
		endcase
	end

	// Cell memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= mem[xy_addr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ttsw_pkg::ST_INIT;
			default_attr_q <= ttsw_pkg::RESET_ATTR;
			row_q          <= '0;
			col_q          <= '0;
			top_q          <= '0;
			fill_addr_q    <= '0;
			fill_cnt_q     <= CNT_W'(CELL_COUNT);
			fill_cell_q    <= {ttsw_pkg::RESET_ATTR, ttsw_pkg::BLANK_CHAR};
			out_valid_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			top_q       <= top_d;
			fill_addr_q <= fill_addr_d;
			fill_cnt_q  <= fill_cnt_d;
			fill_cell_q <= fill_cell_d;
			if (cfg_wr_en) begin
				default_attr_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the input beat, the read data and the result beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			char_q <= char_code;
			x_q    <= col_x;
			y_q    <= row_y;
			attr_q <= attribute;
		end
		cell_q <= cell_d;
		if (load_out) begin
			out_row_q  <= ttsw_pkg::ROW_Y_W'(row_q);
			out_col_q  <= ttsw_pkg::COL_X_W'(col_q);
			out_pos_q  <= ttsw_pkg::POS_W'(pos_full);
			out_cell_q <= cell_q;
		end
	end

	assign in_ready        = (state_q == ttsw_pkg::ST_IDLE);
	assign out_valid       = out_valid_q;
	assign cursor_line     = out_row_q;
	assign cursor_column   = out_col_q;
	assign cursor_position = out_pos_q;
	assign cell_char       = out_cell_q[ttsw_pkg::CHAR_W-1:0];
	assign cell_attr       = out_cell_q[ttsw_pkg::CELL_W-1:ttsw_pkg::CHAR_W];

	// Assertions
	assign cursor_in_range = (int'(row_q) < SCREEN_ROWS) && (int'(col_q) < SCREEN_COLUMNS)
		&& (int'(top_q) < SCREEN_ROWS);
	assign in_work_state   = (state_q == ttsw_pkg::ST_EXEC) || (state_q == ttsw_pkg::ST_FILL)
		|| (state_q == ttsw_pkg::ST_INIT);

	`TTSW_ASSERT_SAME(a_cursor_on_screen, 1'b1, cursor_in_range, "cursor or top row off screen")
	`TTSW_ASSERT_SAME(a_write_in_work_state, mem_we, in_work_state, "memory write outside work")
	`TTSW_ASSERT_NEXT(a_result_from_done, load_out, out_valid_q && in_ready, "result load lost")

endmodule

`default_nettype wire
